>>> rtl/ring_membership_table_unit_macros.svh
// Assertion macros for the ring membership table unit.
// Each macro checks a property on the rising edge of clk and is
// switched off while rst_n is low.
`ifndef RING_MEMBERSHIP_TABLE_UNIT_MACROS_SVH
`define RING_MEMBERSHIP_TABLE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define RMT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define RMT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RMT_ASSERT_IMP(lbl, ante, cons, msg)
`define RMT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/rmt_pkg.sv
`default_nettype none

package rmt_pkg;

  // Table geometry.
  localparam int MAX_NODES = 16;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int PTR_W     = $clog2(MAX_NODES + 1);

  // Field widths of the command and result words.
  localparam int ID_W    = 64;
  localparam int PORT_W  = 16;
  localparam int OP_W    = 3;
  localparam int INDEX_W = 6;
  localparam int CNT_W   = 7;
  localparam int STAT_W  = 2;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_INIT   = 3'd0,
    OP_ADD    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_NEXT   = 3'd3,
    OP_PREV   = 3'd4,
    OP_GET    = 3'd5
  } op_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    RES_OK        = 2'd0,
    RES_INVALID   = 2'd1,
    RES_FULL      = 2'd2,
    RES_NOT_FOUND = 2'd3
  } res_status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_SHIFT,
    S_READ
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        load;       // capture the command word
    logic        rd_nav;     // read the neighbour or indexed entry, latch its position
    logic        ptr_clr;    // restart the scan pointer
    logic        ptr_inc;    // advance the scan pointer
    logic        hit_latch;  // remember the matching position
    logic        wr_init;    // table holds the local node alone
    logic        wr_append;  // append the new node at the end
    logic        wr_shift;   // move one entry down by one place
    logic        rm_commit;  // shrink the table after a removal
    logic        res_valid;  // issue a result word
    res_status_t res_status;
    logic        res_data;   // result carries the entry just read
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic full;         // table has no free entry
    logic pos_ok;       // neighbour or indexed position exists
    logic scan_hit;     // entry just read matches the node identifier
    logic scan_end;     // scan pointer has reached the member count
    logic hit_is_self;  // matching entry is the local node
    logic primed;       // shift read data is ready to be written back
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/rmt_ctrl.sv
`default_nettype none

module rmt_ctrl
  import rmt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire dp_status_t dp_status,
  output dp_cmd_t         dp_cmd,
  output logic            busy
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    dp_cmd    = '0;
    dp_cmd.res_status = RES_OK;
    busy      = (state_r != S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (start) begin
          dp_cmd.load = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        case (dp_status.op)
          OP_INIT: begin
            dp_cmd.wr_init   = 1'b1;
            dp_cmd.res_valid = 1'b1;
            state_nxt        = S_IDLE;
          end
          OP_ADD: begin
            if (dp_status.full) begin
              dp_cmd.res_valid  = 1'b1;
              dp_cmd.res_status = RES_FULL;
              state_nxt         = S_IDLE;
            end else begin
              dp_cmd.ptr_clr = 1'b1;
              state_nxt      = S_SEARCH;
            end
          end
          OP_REMOVE: begin
            dp_cmd.ptr_clr = 1'b1;
            state_nxt      = S_SEARCH;
          end
          OP_NEXT, OP_PREV, OP_GET: begin
            if (dp_status.pos_ok) begin
              dp_cmd.rd_nav = 1'b1;
              state_nxt     = S_READ;
            end else begin
              dp_cmd.res_valid  = 1'b1;
              dp_cmd.res_status = RES_INVALID;
              state_nxt         = S_IDLE;
            end
          end
          default: begin
            dp_cmd.res_valid  = 1'b1;
            dp_cmd.res_status = RES_INVALID;
            state_nxt         = S_IDLE;
          end
        endcase
      end

      // One entry is read per cycle; the compare sees the previous one.
      S_SEARCH: begin
        if (dp_status.scan_hit) begin
          if (dp_status.op == OP_ADD) begin
            dp_cmd.res_valid = 1'b1;
            state_nxt        = S_IDLE;
          end else if (dp_status.hit_is_self) begin
            dp_cmd.res_valid  = 1'b1;
            dp_cmd.res_status = RES_INVALID;
            state_nxt         = S_IDLE;
          end else begin
            dp_cmd.hit_latch = 1'b1;
            state_nxt        = S_SHIFT;
          end
        end else if (dp_status.scan_end) begin
          dp_cmd.res_valid = 1'b1;
          state_nxt        = S_IDLE;
          if (dp_status.op == OP_ADD) begin
            dp_cmd.wr_append = 1'b1;
          end else begin
            dp_cmd.res_status = RES_NOT_FOUND;
          end
        end else begin
          dp_cmd.ptr_inc = 1'b1;
        end
      end

      // Close the gap: read one entry ahead, write it one place down.
      S_SHIFT: begin
        dp_cmd.wr_shift = dp_status.primed;
        if (dp_status.scan_end) begin
          dp_cmd.rm_commit = 1'b1;
          dp_cmd.res_valid = 1'b1;
          state_nxt        = S_IDLE;
        end else begin
          dp_cmd.ptr_inc = 1'b1;
        end
      end

      S_READ: begin
        dp_cmd.res_valid = 1'b1;
        dp_cmd.res_data  = 1'b1;
        state_nxt        = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/rmt_datapath.sv
`default_nettype none

module rmt_datapath
  import rmt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dp_cmd_t            dp_cmd,
  output dp_status_t              dp_status,
  input  wire logic               cfg_wr_en,
  input  wire logic [ID_W-1:0]    cfg_wr_data,
  input  wire logic [OP_W-1:0]    in_operation,
  input  wire logic [ID_W-1:0]    in_node_id,
  input  wire logic [PORT_W-1:0]  in_node_port,
  input  wire logic [INDEX_W-1:0] in_entry_index,
  output logic                    out_valid,
  output logic [STAT_W-1:0]       out_status,
  output logic [ID_W-1:0]         out_found_id,
  output logic [PORT_W-1:0]       out_found_port,
  output logic [INDEX_W-1:0]      out_found_index,
  output logic [CNT_W-1:0]        out_member_count
);

  // Configuration and table state.
  logic [ID_W-1:0]    self_node_id_r;
  logic [PTR_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   self_pos_r, self_pos_nxt;

  // Captured command word.
  op_t                op_r;
  logic [ID_W-1:0]    key_id_r;
  logic [PORT_W-1:0]  key_port_r;
  logic [INDEX_W-1:0] key_index_r;

  // Scan pointer and latched position.
  logic [PTR_W-1:0]   ptr_r;
  logic [IDX_W-1:0]   pos_r;

  // Table memory.
  logic [ID_W-1:0]    mem_id   [MAX_NODES];
  logic [PORT_W-1:0]  mem_port [MAX_NODES];
  logic               id0_valid_r;
  logic [ID_W-1:0]    rd_id_raw_r;
  logic [PORT_W-1:0]  rd_port_r;
  logic               rd_zero_r;
  logic [ID_W-1:0]    rd_id;

  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ID_W-1:0]    wr_id;
  logic [PORT_W-1:0]  wr_port;

  logic [PTR_W-1:0]   ptr_m1;
  logic [PTR_W-1:0]   self_ext;
  logic [PTR_W-1:0]   self_p1;
  logic [IDX_W-1:0]   pos_c;
  logic               pos_ok_c;

  // Output word registers.
  logic                    out_valid_r;
  logic [STAT_W-1:0]       out_status_r;
  logic [ID_W-1:0]         out_found_id_r;
  logic [PORT_W-1:0]       out_found_port_r;
  logic [INDEX_W-1:0]      out_found_index_r;
  logic [CNT_W-1:0]        out_member_count_r;

  function automatic logic [IDX_W-1:0] ptr_trunc(input logic [PTR_W-1:0] v);
    ptr_trunc = v[IDX_W-1:0];
  endfunction

  // Entry zero reads as zero until first written.
  assign rd_id = rd_zero_r ? '0 : rd_id_raw_r;

  // Neighbour and indexed positions.
  assign self_ext = PTR_W'(self_pos_r);
  assign self_p1  = self_ext + PTR_W'(1);
  assign ptr_m1   = ptr_r - PTR_W'(1);

  always_comb begin
    pos_c    = '0;
    pos_ok_c = 1'b0;
    case (op_r)
      OP_NEXT: begin
        pos_c    = (self_p1 == count_r) ? '0 : self_p1[IDX_W-1:0];
        pos_ok_c = (count_r != '0);
      end
      OP_PREV: begin
        pos_c    = (self_pos_r == '0) ? ptr_trunc(count_r - PTR_W'(1))
                                      : self_pos_r - IDX_W'(1);
        pos_ok_c = (count_r != '0);
      end
      OP_GET: begin
        pos_c    = key_index_r[IDX_W-1:0];
        pos_ok_c = (CNT_W'(key_index_r) < CNT_W'(count_r));
      end
      default: begin
        pos_c    = '0;
        pos_ok_c = 1'b0;
      end
    endcase
  end

  // Status towards the controller.
  always_comb begin
    dp_status.op          = op_r;
    dp_status.full        = (count_r >= PTR_W'(MAX_NODES));
    dp_status.pos_ok      = pos_ok_c;
    dp_status.scan_hit    = (ptr_r != '0) && (rd_id == key_id_r);
    dp_status.scan_end    = (ptr_r == count_r);
    dp_status.hit_is_self = (ptr_m1 == self_ext);
    dp_status.primed      = (ptr_r != (PTR_W'(pos_r) + PTR_W'(1)));
  end

  // Memory port selection.
  always_comb begin
    rd_addr = dp_cmd.rd_nav ? pos_c : ptr_r[IDX_W-1:0];
    wr_en   = dp_cmd.wr_init | dp_cmd.wr_append | dp_cmd.wr_shift;
    wr_addr = '0;
    wr_id   = self_node_id_r;
    wr_port = '0;
    if (dp_cmd.wr_append) begin
      wr_addr = count_r[IDX_W-1:0];
      wr_id   = key_id_r;
      wr_port = key_port_r;
    end else if (dp_cmd.wr_shift) begin
      wr_addr = ptr_trunc(ptr_r - PTR_W'(2));
      wr_id   = rd_id;
      wr_port = rd_port_r;
    end
  end

  // Table memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_id[wr_addr]   <= wr_id;
      mem_port[wr_addr] <= wr_port;
    end
    rd_id_raw_r <= mem_id[rd_addr];
    rd_port_r   <= mem_port[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id0_valid_r <= 1'b0;
      rd_zero_r   <= 1'b1;
    end else begin
      rd_zero_r <= (rd_addr == '0) && !id0_valid_r;
      if (wr_en && (wr_addr == '0)) begin
        id0_valid_r <= 1'b1;
      end
    end
  end

  // Count and local position updates.
  always_comb begin
    count_nxt    = count_r;
    self_pos_nxt = self_pos_r;
    if (dp_cmd.wr_init) begin
      count_nxt    = PTR_W'(1);
      self_pos_nxt = '0;
    end else if (dp_cmd.wr_append) begin
      count_nxt = count_r + PTR_W'(1);
    end else if (dp_cmd.rm_commit) begin
      count_nxt = count_r - PTR_W'(1);
      if (pos_r < self_pos_r) begin
        self_pos_nxt = self_pos_r - IDX_W'(1);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_node_id_r <= '0;
      count_r        <= PTR_W'(1);
      self_pos_r     <= '0;
      ptr_r          <= '0;
      op_r           <= OP_INIT;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        self_node_id_r <= cfg_wr_data;
      end
      count_r     <= count_nxt;
      self_pos_r  <= self_pos_nxt;
      out_valid_r <= dp_cmd.res_valid;
      if (dp_cmd.load) begin
        op_r <= op_t'(in_operation);
      end
      if (dp_cmd.ptr_clr) begin
        ptr_r <= '0;
      end else if (dp_cmd.ptr_inc) begin
        ptr_r <= ptr_r + PTR_W'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      key_id_r    <= in_node_id;
      key_port_r  <= in_node_port;
      key_index_r <= in_entry_index;
    end
    if (dp_cmd.rd_nav) begin
      pos_r <= pos_c;
    end else if (dp_cmd.hit_latch) begin
      pos_r <= ptr_m1[IDX_W-1:0];
    end
    if (dp_cmd.res_valid) begin
      out_status_r       <= dp_cmd.res_status;
      out_member_count_r <= CNT_W'(count_nxt);
      if (dp_cmd.res_data) begin
        out_found_id_r    <= rd_id;
        out_found_port_r  <= rd_port_r;
        out_found_index_r <= INDEX_W'(pos_r);
      end else begin
        out_found_id_r    <= '0;
        out_found_port_r  <= '0;
        out_found_index_r <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found_id     = out_found_id_r;
  assign out_found_port   = out_found_port_r;
  assign out_found_index  = out_found_index_r;
  assign out_member_count = out_member_count_r;

endmodule

`default_nettype wire

>>> rtl/ring_membership_table_unit.sv
`default_nettype none

// Ring membership table: an ordered, compacted list of member node
// identifiers and ports, with the local node at a tracked position.
// A command word is taken when start is high and busy is low; busy stays
// high until the single result word for it has been issued. Each result
// word is shown for exactly one cycle with out_valid high; the receiver
// cannot stall it. The self_node_id register is written through cfg_wr_en
// and cfg_wr_data; the user must write it only while the block is idle.
// The block itself does not enforce this.
// The table memory has one read and one write port and is scanned one
// entry per cycle; a removal carries on from the matching entry to
// shift the later ones down, so search and shift pass each entry once.
// A new command may be accepted in the cycle its predecessor's result is
// shown. After reset the table holds one entry, identifier zero, at
// position zero, and self_node_id is zero.
module ring_membership_table_unit
  import rmt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [ID_W-1:0]    cfg_wr_data,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [OP_W-1:0]    in_operation,
  input  wire logic [ID_W-1:0]    in_node_id,
  input  wire logic [PORT_W-1:0]  in_node_port,
  input  wire logic [INDEX_W-1:0] in_entry_index,
  output logic                    out_valid,
  output logic [STAT_W-1:0]       out_status,
  output logic [ID_W-1:0]         out_found_id,
  output logic [PORT_W-1:0]       out_found_port,
  output logic [INDEX_W-1:0]      out_found_index,
  output logic [CNT_W-1:0]        out_member_count
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // Sequencer.
  rmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd),
    .busy      (busy)
  );

  // Table storage and result word.
  rmt_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .dp_cmd           (dp_cmd),
    .dp_status        (dp_status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_operation     (in_operation),
    .in_node_id       (in_node_id),
    .in_node_port     (in_node_port),
    .in_entry_index   (in_entry_index),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_found_id     (out_found_id),
    .out_found_port   (out_found_port),
    .out_found_index  (out_found_index),
    .out_member_count (out_member_count)
  );

`include "ring_membership_table_unit_macros.svh"

  // A result word never lasts more than one cycle.
  `RMT_ASSERT_NXT(a_single_word, out_valid, !out_valid, "result strobe held for two cycles")
  // The member count always stays within the table.
  `RMT_ASSERT_IMP(a_count_range, out_valid, (out_member_count != '0) && (out_member_count <= CNT_W'(MAX_NODES)), "member count out of range")
  // An accepted command makes the block busy.
  `RMT_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted command did not raise busy")
  // A result is only issued while a command is in progress.
  `RMT_ASSERT_IMP(a_result_busy, dp_cmd.res_valid, busy, "result issued while idle")

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
import rmt_pkg::*;

// One result word as the table should report it.
typedef struct packed {
  logic [STAT_W-1:0]  status;
  logic [ID_W-1:0]    found_id;
  logic [PORT_W-1:0]  found_port;
  logic [INDEX_W-1:0] found_index;
  logic [CNT_W-1:0]   member_count;
} membership_word_t;

// Shadow copy of the membership table and the words it should produce.
class membership_scoreboard;
  logic [ID_W-1:0]   self_id;
  logic [ID_W-1:0]   ids [MAX_NODES];
  logic [PORT_W-1:0] ports [MAX_NODES];
  int unsigned       members;
  int unsigned       self_pos;
  membership_word_t  awaited [$];
  int unsigned       mismatches;

  function new();
    self_id = '0;
    foreach (ids[i]) begin
      ids[i] = '0;
      ports[i] = '0;
    end
    members = 1;
    self_pos = 0;
    mismatches = 0;
  endfunction

  // Applies one accepted command word to the shadow table and queues its result.
  function void note_command(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                             logic [PORT_W-1:0] port, logic [INDEX_W-1:0] idx);
    membership_word_t w;
    bit               hit;
    int unsigned      pos;
    int               slot;
    int               i;
    w = '0;
    w.status = RES_INVALID;
    hit = 1'b0;
    pos = 0;
    slot = -1;
    case (op)
      OP_INIT: begin
        foreach (ids[k]) begin
          ids[k] = '0;
          ports[k] = '0;
        end
        ids[0] = self_id;
        members = 1;
        self_pos = 0;
        w.status = RES_OK;
      end
      OP_ADD: begin
        // A full table is refused before any search for a duplicate.
        if (members >= MAX_NODES) begin
          w.status = RES_FULL;
        end else begin
          w.status = RES_OK;
          for (i = 0; i < int'(members); i++) begin
            if (ids[i] == id) slot = i;
          end
          if (slot < 0) begin
            ids[members] = id;
            ports[members] = port;
            members++;
          end
        end
      end
      OP_REMOVE: begin
        for (i = int'(members) - 1; i >= 0; i--) begin
          if (ids[i] == id) slot = i;
        end
        if (slot < 0) begin
          w.status = RES_NOT_FOUND;
        end else if (slot == int'(self_pos)) begin
          w.status = RES_INVALID;
        end else begin
          // Close the gap by moving every later entry down one place.
          for (i = slot; i + 1 < int'(members); i++) begin
            ids[i] = ids[i + 1];
            ports[i] = ports[i + 1];
          end
          members--;
          if (slot < int'(self_pos)) self_pos--;
          w.status = RES_OK;
        end
      end
      OP_NEXT: begin
        if (members == 0) begin
          w.status = RES_NOT_FOUND;
        end else begin
          pos = (self_pos + 1) % members;
          hit = 1'b1;
        end
      end
      OP_PREV: begin
        if (members == 0) begin
          w.status = RES_NOT_FOUND;
        end else begin
          pos = (self_pos + members - 1) % members;
          hit = 1'b1;
        end
      end
      OP_GET: begin
        if (idx < members) begin
          pos = idx;
          hit = 1'b1;
        end
      end
      default: begin
        w.status = RES_INVALID;
      end
    endcase
    if (hit && pos < MAX_NODES) begin
      w.status = RES_OK;
      w.found_id = ids[pos];
      w.found_port = ports[pos];
      w.found_index = INDEX_W'(pos);
    end
    w.member_count = CNT_W'(members);
    awaited.push_back(w);
  endfunction

  // Prints one line per mismatch and counts it.
  task report(string what, logic [ID_W-1:0] got, logic [ID_W-1:0] want);
    mismatches++;
    $display("mismatch in %s: got %0h, expected %0h", what, got, want);
  endtask

  // Compares a result word with the oldest outstanding expectation.
  task check_result(logic [STAT_W-1:0] status, logic [ID_W-1:0] found_id,
                    logic [PORT_W-1:0] found_port, logic [INDEX_W-1:0] found_index,
                    logic [CNT_W-1:0] member_count);
    membership_word_t w;
    if (awaited.size() == 0) begin
      report("result word with no command outstanding", ID_W'(status), '0);
      return;
    end
    w = awaited.pop_front();
    if (status !== w.status) report("status", ID_W'(status), ID_W'(w.status));
    if (found_id !== w.found_id) report("found_id", found_id, w.found_id);
    if (found_port !== w.found_port) begin
      report("found_port", ID_W'(found_port), ID_W'(w.found_port));
    end
    if (found_index !== w.found_index) begin
      report("found_index", ID_W'(found_index), ID_W'(w.found_index));
    end
    if (member_count !== w.member_count) begin
      report("member_count", ID_W'(member_count), ID_W'(w.member_count));
    end
  endtask
endclass

module tb;
  localparam int unsigned CYCLE_LIMIT     = 500_000;
  localparam int unsigned DRAIN_CYCLES    = 2 * MAX_NODES + 8;
  localparam int unsigned ITEMS_PER_PHASE = 345;
  localparam logic [OP_W-1:0] OP_BAD_LO   = 3'd6;
  localparam logic [OP_W-1:0] OP_BAD_HI   = 3'd7;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [ID_W-1:0]    cfg_wr_data;
  logic               start;
  logic               busy;
  logic [OP_W-1:0]    in_operation;
  logic [ID_W-1:0]    in_node_id;
  logic [PORT_W-1:0]  in_node_port;
  logic [INDEX_W-1:0] in_entry_index;
  logic               out_valid;
  logic [STAT_W-1:0]  out_status;
  logic [ID_W-1:0]    out_found_id;
  logic [PORT_W-1:0]  out_found_port;
  logic [INDEX_W-1:0] out_found_index;
  logic [CNT_W-1:0]   out_member_count;

  membership_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned idle_pct = 0;
  bit          growing = 1'b1;

  ring_membership_table_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_node_id       (in_node_id),
    .in_node_port     (in_node_port),
    .in_entry_index   (in_entry_index),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_found_id     (out_found_id),
    .out_found_port   (out_found_port),
    .out_found_index  (out_found_index),
    .out_member_count (out_member_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Every strobed result word is checked at the edge that ends its cycle.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      sb.check_result(out_status, out_found_id, out_found_port, out_found_index,
                      out_member_count);
    end
  end

  task automatic idle_cycles(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Random gaps in front of a word, per cycle at the current idle rate.
  task automatic pause_sender();
    while ($urandom_range(99) < idle_pct) idle_cycles(1);
  endtask

  // Presents one command word and holds it until the block takes it.
  task automatic send_command(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                              logic [PORT_W-1:0] port, logic [INDEX_W-1:0] idx);
    bit taken;
    taken = 1'b0;
    start <= 1'b1;
    in_operation <= op;
    in_node_id <= id;
    in_node_port <= port;
    in_entry_index <= idx;
    while (!taken) begin
      @(posedge clk);
      if (busy === 1'b0) begin
        taken = 1'b1;
        sb.note_command(op, id, port, idx);
      end
    end
  endtask

  // The local identifier is only changed once every result has come back.
  task automatic write_self_id(logic [ID_W-1:0] value);
    start <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.self_id = value;
  endtask

  // Picks a command that mostly grows or mostly shrinks the table, drawing
  // identifiers from the current members so that removals and duplicates hit.
  task automatic send_random_command();
    logic [OP_W-1:0]    op;
    logic [ID_W-1:0]    id;
    logic [PORT_W-1:0]  port;
    logic [INDEX_W-1:0] idx;
    int unsigned        roll;
    id = {$urandom, $urandom};
    port = PORT_W'($urandom);
    idx = INDEX_W'($urandom);
    if ($urandom_range(39) == 0) growing = !growing;
    if (sb.members == MAX_NODES && $urandom_range(5) == 0) growing = 1'b0;
    if (sb.members <= 2 && $urandom_range(5) == 0) growing = 1'b1;
    roll = $urandom_range(99);
    if (roll < 2) begin
      op = OP_INIT;
    end else if (roll < (growing ? 50 : 14)) begin
      op = OP_ADD;
    end else if (roll < (growing ? 62 : 55)) begin
      op = OP_REMOVE;
    end else if (roll < 69) begin
      op = OP_NEXT;
    end else if (roll < 76) begin
      op = OP_PREV;
    end else if (roll < 95) begin
      op = OP_GET;
    end else begin
      op = $urandom_range(1) ? OP_BAD_HI : OP_BAD_LO;
    end
    case (op)
      OP_ADD: begin
        roll = $urandom_range(9);
        if (roll < 2) id = sb.ids[$urandom_range(sb.members - 1)];
        else if (roll == 2) id = $urandom_range(1) ? '1 : '0;
        if ($urandom_range(9) == 0) port = $urandom_range(1) ? '1 : '0;
      end
      OP_REMOVE: begin
        if ($urandom_range(9) < 7) id = sb.ids[$urandom_range(sb.members - 1)];
      end
      OP_GET: begin
        if ($urandom_range(9) < 8) idx = INDEX_W'($urandom_range(sb.members - 1));
      end
      default: begin
      end
    endcase
    send_command(op, id, port, idx);
  endtask

  task automatic run_random_phase(int unsigned pct, int unsigned n);
    idle_pct = pct;
    repeat (n) begin
      pause_sender();
      send_random_command();
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    start <= 1'b0;
    in_operation <= OP_INIT;
    in_node_id <= '0;
    in_node_port <= '0;
    in_entry_index <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: the table is set up first so that no unwritten port is read.
    idle_pct = 8;
    write_self_id('0);
    send_command(OP_INIT, '1, '1, '1);
    send_command(OP_GET, '0, '0, 6'd0);
    send_command(OP_NEXT, '0, '0, '0);
    send_command(OP_PREV, '0, '0, '0);
    // Adding the local identifier again is a duplicate.
    send_command(OP_ADD, '0, '1, '0);
    send_command(OP_ADD, '1, '1, '0);
    send_command(OP_ADD, 64'd1, '0, '0);
    send_command(OP_ADD, 64'h8000_0000_0000_0000, 16'h8000, '0);
    send_command(OP_NEXT, '0, '0, '0);
    send_command(OP_PREV, '0, '0, '0);
    send_command(OP_GET, '0, '0, 6'd3);
    // Indexes at and far beyond the member count.
    send_command(OP_GET, '0, '0, 6'd4);
    send_command(OP_GET, '0, '0, '1);
    // Removing the local node, then an identifier that is not present.
    send_command(OP_REMOVE, '0, '0, '0);
    send_command(OP_REMOVE, 64'h0123_4567_89ab_cdef, '0, '0);
    send_command(OP_REMOVE, '1, '0, '0);
    send_command(OP_GET, '0, '0, 6'd1);
    send_command(OP_BAD_LO, '1, '1, '1);
    send_command(OP_BAD_HI, '0, '0, '0);
    send_command(OP_REMOVE, 64'h8000_0000_0000_0000, '0, '0);

    // Random part: sender idles rarely, then often, then not at all.
    write_self_id('1);
    send_command(OP_INIT, '0, '0, '0);
    run_random_phase(8, ITEMS_PER_PHASE);
    write_self_id({$urandom, $urandom});
    run_random_phase(88, ITEMS_PER_PHASE);
    write_self_id({$urandom, $urandom});
    send_command(OP_INIT, '0, '0, '0);
    run_random_phase(0, ITEMS_PER_PHASE);

    // Drain: wait for every outstanding word, then watch for strays.
    start <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
